// ===== rtl/vertex_transform_project_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the vertex transform and projection unit
// Shared concurrent assertion forms, clocked by clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_PROJECT_UNIT_ASSERT_SVH
`define VERTEX_TRANSFORM_PROJECT_UNIT_ASSERT_SVH

// same-cycle implication
`define VTP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vtp assertion failed");

// next-cycle implication
`define VTP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vtp assertion failed");

`endif

// ===== rtl/vtp_pkg.sv =====
// ---------------------------------------------------------------------------
// vtp_pkg
// Types and constants shared by the vertex transform and projection unit.
// ---------------------------------------------------------------------------
`default_nettype none
package vtp_pkg;

	localparam int unsigned MAX_SCREEN_DIM_DEF  = 4096;
	localparam int unsigned COORD_FRAC_BITS_DEF = 16;

	localparam int unsigned COORD_W    = 32;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned N_ENTRIES  = 16;
	localparam int unsigned DIM_CFG_W  = 13;
	localparam int unsigned PIX_W      = 12;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);

	localparam logic [DIM_CFG_W-1:0] RESET_WIDTH  = 13'd640;
	localparam logic [DIM_CFG_W-1:0] RESET_HEIGHT = 13'd480;

	// register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// item commands
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_VERTEX = 1'b1;

	typedef struct packed {
		logic                       cmd;
		logic [IDX_W-1:0]           entry_index;
		logic signed [COORD_W-1:0]  entry_value;
		logic signed [COORD_W-1:0]  vertex_x;
		logic signed [COORD_W-1:0]  vertex_y;
		logic signed [COORD_W-1:0]  vertex_z;
	} item_t;

	// transformed vertex handed from the transform stage to projection
	typedef struct packed {
		logic                       valid;
		logic signed [COORD_W-1:0]  cx;
		logic signed [COORD_W-1:0]  cy;
		logic signed [COORD_W-1:0]  cw;
	} xf_t;

endpackage
`default_nettype wire

// ===== rtl/vtp_if.sv =====
// ---------------------------------------------------------------------------
// vtp channel interfaces
// Valid/ready channels for input items and projected results.
// ---------------------------------------------------------------------------
`default_nettype none
interface vtp_in_if;
	import vtp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [IDX_W-1:0]          entry_index;
	logic signed [COORD_W-1:0] entry_value;
	logic signed [COORD_W-1:0] vertex_x;
	logic signed [COORD_W-1:0] vertex_y;
	logic signed [COORD_W-1:0] vertex_z;

	modport source (output valid, cmd, entry_index, entry_value, vertex_x, vertex_y,
		vertex_z, input ready);
	modport sink (input valid, cmd, entry_index, entry_value, vertex_x, vertex_y,
		vertex_z, output ready);
endinterface

interface vtp_out_if;
	import vtp_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;
	logic             visible;

	modport source (output valid, pixel_x, pixel_y, visible, input ready);
	modport sink (input valid, pixel_x, pixel_y, visible, output ready);
endinterface
`default_nettype wire

// ===== rtl/vtp_front.sv =====
// ---------------------------------------------------------------------------
// vtp_front
// Accepts items, each carrying its load or vertex cmd, and queues them for the back end.
// ---------------------------------------------------------------------------
`default_nettype none
`include "vertex_transform_project_unit_assert.svh"
module vtp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	vtp_in_if.sink             req,
	input  wire logic          pop,
	output logic               pop_valid,
	output vtp_pkg::item_t     pop_item
);
	import vtp_pkg::*;

	item_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    cnt_q;
	logic               push;
	logic               pop_fire;
	item_t              in_item;

	always_comb begin
		in_item.cmd         = req.cmd;
		in_item.entry_index = req.entry_index;
		in_item.entry_value = req.entry_value;
		in_item.vertex_x    = req.vertex_x;
		in_item.vertex_y    = req.vertex_y;
		in_item.vertex_z    = req.vertex_z;
	end

	assign req.ready = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign pop_valid = (cnt_q != '0);
	assign pop_fire  = pop && pop_valid;
	assign pop_item  = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop_fire})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`VTP_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= (QPTR_W+1)'(QUEUE_DEPTH))
	`VTP_ASSERT_IMP(a_ptr_gap, 1'b1, (wr_ptr_q - rd_ptr_q) == cnt_q[QPTR_W-1:0])
	`VTP_ASSERT_NXT(a_push_only, push && !pop_fire, cnt_q == $past(cnt_q) + 1'b1)

endmodule
`default_nettype wire

// ===== rtl/vtp_xform.sv =====
// ---------------------------------------------------------------------------
// vtp_xform
// Matrix store, matrix loads and the vertex-by-matrix product (two stages).
// ---------------------------------------------------------------------------
`default_nettype none
module vtp_xform #(
	parameter int unsigned COORD_FRAC_BITS = vtp_pkg::COORD_FRAC_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          pop_valid,
	input  vtp_pkg::item_t     pop_item,
	output vtp_pkg::xf_t       xf
);
	import vtp_pkg::*;

	localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

	logic signed [COORD_W-1:0] mat_q [N_ENTRIES];
	logic                      valid_s1;
	logic signed [63:0]        prod_s1 [3][3];
	logic signed [COORD_W-1:0] bias_s1 [3];
	logic                      valid_s2;
	logic signed [COORD_W-1:0] col_s2 [3];
	logic signed [COORD_W-1:0] coord [3];
	logic signed [63:0]        sum [3];
	logic                      take;

	assign take     = adv && pop_valid;
	assign coord[0] = pop_item.vertex_x;
	assign coord[1] = pop_item.vertex_y;
	assign coord[2] = pop_item.vertex_z;

	// matrix loads take effect in queue order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_ENTRIES; i++) begin
				mat_q[i] <= '0;
			end
		end else if (take && pop_item.cmd == CMD_LOAD) begin
			mat_q[pop_item.entry_index] <= pop_item.entry_value;
		end
	end

	// stage 1: nine products, columns 0, 1 and 3
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					prod_s1[c][r] <= coord[r] * mat_q[r*4 + ((c == 2) ? 3 : c)];
				end
				bias_s1[c] <= mat_q[12 + ((c == 2) ? 3 : c)];
			end
		end
	end

	// stage 2: floor shift, sum, saturate
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = (prod_s1[c][0] >>> COORD_FRAC_BITS) + (prod_s1[c][1] >>> COORD_FRAC_BITS)
				+ (prod_s1[c][2] >>> COORD_FRAC_BITS) + bias_s1[c];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				if (sum[c] > SAT_MAX) begin
					col_s2[c] <= SAT_MAX[COORD_W-1:0];
				end else if (sum[c] < SAT_MIN) begin
					col_s2[c] <= SAT_MIN[COORD_W-1:0];
				end else begin
					col_s2[c] <= sum[c][COORD_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= take && pop_item.cmd == CMD_VERTEX;
			valid_s2 <= valid_s1;
		end
	end

	assign xf.valid = valid_s2;
	assign xf.cx    = col_s2[0];
	assign xf.cy    = col_s2[1];
	assign xf.cw    = col_s2[2];

endmodule
`default_nettype wire

// ===== rtl/vtp_project.sv =====
// ---------------------------------------------------------------------------
// vtp_project
// Viewport mapping, bounds test and pipelined divide by 2W; output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "vertex_transform_project_unit_assert.svh"
module vtp_project #(
	parameter int unsigned MAX_SCREEN_DIM = vtp_pkg::MAX_SCREEN_DIM_DEF,
	localparam int unsigned DIM_W = $clog2(MAX_SCREEN_DIM + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     adv,
	input  vtp_pkg::xf_t                  xf,
	input  wire logic [DIM_W-1:0]         dw,
	input  wire logic [DIM_W-1:0]         dh,
	output logic                          out_valid,
	output logic [vtp_pkg::PIX_W-1:0]     pix_x,
	output logic [vtp_pkg::PIX_W-1:0]     pix_y,
	output logic                          vis
);
	import vtp_pkg::*;

	localparam int unsigned QW    = $clog2(MAX_SCREEN_DIM);
	localparam int unsigned NUM_W = DIM_W + 35;
	localparam int unsigned DEN_W = 33;
	localparam int unsigned LIM_W = DEN_W + DIM_W;

	// stage 3
	logic signed [33:0]       ax, ay;
	logic signed [DEN_W-1:0]  w2;
	logic [DEN_W-1:0]         den_abs;
	logic                     valid_s3, neg_s3, zero_s3;
	logic signed [NUM_W-1:0]  numx_s3, numy_s3;
	logic [DEN_W-1:0]         den_s3;
	logic [LIM_W-1:0]         limx_s3, limy_s3;

	// stage 4
	logic signed [NUM_W-1:0]  nx, ny;
	logic                     okx, oky;

	// divider chain, index 0 is the stage 4 output
	logic [QW:0]              v_d;
	logic                     vis_d [QW+1];
	logic [DEN_W-1:0]         den_d [QW+1];
	logic [LIM_W-1:0]         rx_d [QW+1];
	logic [LIM_W-1:0]         ry_d [QW+1];
	logic [QW-1:0]            qx_d [QW+1];
	logic [QW-1:0]            qy_d [QW+1];

	logic [PIX_W-1:0]         pix_x_q, pix_y_q;
	logic                     vis_q, out_valid_q;

	assign ax      = {xf.cx[COORD_W-1], xf.cx, 1'b0} + {{2{xf.cw[COORD_W-1]}}, xf.cw};
	assign ay      = {{2{xf.cw[COORD_W-1]}}, xf.cw} - {xf.cy[COORD_W-1], xf.cy, 1'b0};
	assign w2      = {xf.cw, 1'b0};
	assign den_abs = w2[DEN_W-1] ? DEN_W'(-w2) : DEN_W'(w2);

	always_ff @(posedge clk) begin
		if (adv) begin
			numx_s3 <= ax * $signed({1'b0, dw});
			numy_s3 <= ay * $signed({1'b0, dh});
			den_s3  <= den_abs;
			limx_s3 <= den_abs * dw;
			limy_s3 <= den_abs * dh;
			neg_s3  <= xf.cw[COORD_W-1];
			zero_s3 <= (xf.cw == '0);
		end
	end

	// stage 4: fold the sign of W into the numerator, range test
	always_comb begin
		nx  = neg_s3 ? -numx_s3 : numx_s3;
		ny  = neg_s3 ? -numy_s3 : numy_s3;
		okx = !nx[NUM_W-1] && ($unsigned(nx) < NUM_W'(limx_s3));
		oky = !ny[NUM_W-1] && ($unsigned(ny) < NUM_W'(limy_s3));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_d[0] <= !zero_s3 && okx && oky;
			den_d[0] <= den_s3;
			rx_d[0]  <= nx[LIM_W-1:0];
			ry_d[0]  <= ny[LIM_W-1:0];
			qx_d[0]  <= '0;
			qy_d[0]  <= '0;
		end
	end

	// restoring divide, one quotient bit per stage, MSB first
	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int unsigned B = QW - 1 - k;
		logic [LIM_W-1:0] trial;
		assign trial = LIM_W'(den_d[k]) << B;

		always_ff @(posedge clk) begin
			if (adv) begin
				vis_d[k+1] <= vis_d[k];
				den_d[k+1] <= den_d[k];
				if (rx_d[k] >= trial) begin
					rx_d[k+1] <= rx_d[k] - trial;
					qx_d[k+1] <= qx_d[k] | (QW'(1) << B);
				end else begin
					rx_d[k+1] <= rx_d[k];
					qx_d[k+1] <= qx_d[k];
				end
				if (ry_d[k] >= trial) begin
					ry_d[k+1] <= ry_d[k] - trial;
					qy_d[k+1] <= qy_d[k] | (QW'(1) << B);
				end else begin
					ry_d[k+1] <= ry_d[k];
					qy_d[k+1] <= qy_d[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_q   <= vis_d[QW];
			pix_x_q <= vis_d[QW] ? PIX_W'(qx_d[QW]) : '0;
			pix_y_q <= vis_d[QW] ? PIX_W'(qy_d[QW]) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			v_d         <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s3    <= xf.valid;
			v_d         <= {v_d[QW-1:0], valid_s3};
			out_valid_q <= v_d[QW];
		end
	end

	assign out_valid = out_valid_q;
	assign pix_x     = pix_x_q;
	assign pix_y     = pix_y_q;
	assign vis       = vis_q;

	`VTP_ASSERT_IMP(a_hidden_zero, out_valid_q && !vis_q, pix_x_q == '0 && pix_y_q == '0)
	`VTP_ASSERT_NXT(a_s3_fill, adv && xf.valid, valid_s3)
	`VTP_ASSERT_NXT(a_out_fill, adv && v_d[QW], out_valid_q)

endmodule
`default_nettype wire

// ===== rtl/vertex_transform_project_unit.sv =====
// ---------------------------------------------------------------------------
// vertex_transform_project_unit
// Vertex transform, perspective divide and viewport mapping, Q16.16.
// ---------------------------------------------------------------------------
// Usage:
//  - req carries items: cmd=0 loads one matrix entry (no result), cmd=1
//    carries a vertex that yields exactly one result on rsp.
//  - Both channels are valid/ready; a transfer happens when both are high.
//  - wr_en/wr_index/wr_data set screen width (index 0) and height (index 1);
//    write only while the unit is idle.
//  - Throughput: one item per clock while rsp does not stall. A vertex passes
//    through the queue, the two transform stages, stages 3 and 4, the one-bit-
//    per-stage divide by 2W for both axes and the output register.
//  - A 4-entry queue sits between the front end and the pipeline; req.ready
//    drops only when that queue is full.
//  - When rsp stalls, the whole back pipeline holds; the queue absorbs
//    items until full.
//  - Reset clears the matrix to zero, the queue and all valid bits, and
//    sets the screen to 640 x 480.
// ---------------------------------------------------------------------------
`default_nettype none
module vertex_transform_project_unit #(
	parameter int unsigned MAX_SCREEN_DIM  = vtp_pkg::MAX_SCREEN_DIM_DEF,
	parameter int unsigned COORD_FRAC_BITS = vtp_pkg::COORD_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic                          wr_index,
	input  wire logic [vtp_pkg::DIM_CFG_W-1:0] wr_data,
	vtp_in_if.sink                             req,
	vtp_out_if.source                          rsp
);
	import vtp_pkg::*;

	localparam int unsigned DIM_W = $clog2(MAX_SCREEN_DIM + 1);

	logic [DIM_CFG_W-1:0] width_q, height_q;
	logic [DIM_W-1:0]     dw, dh;
	logic                 adv;
	logic                 pop_valid;
	item_t                pop_item;
	xf_t                  xf;
	logic                 out_valid;

	// screen size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (wr_en) begin
			case (wr_index)
				REG_WIDTH:  width_q  <= wr_data;
				REG_HEIGHT: height_q <= wr_data;
				default:    width_q  <= width_q;
			endcase
		end
	end

	// clamp to the largest supported dimension
	assign dw = (32'(width_q) > 32'(MAX_SCREEN_DIM))  ? DIM_W'(MAX_SCREEN_DIM) : DIM_W'(width_q);
	assign dh = (32'(height_q) > 32'(MAX_SCREEN_DIM)) ? DIM_W'(MAX_SCREEN_DIM) : DIM_W'(height_q);

	// the back pipeline moves whenever the output register is free
	assign adv = !out_valid || rsp.ready;

	vtp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.pop       (adv),
		.pop_valid (pop_valid),
		.pop_item  (pop_item)
	);

	vtp_xform #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.xf        (xf)
	);

	vtp_project #(
		.MAX_SCREEN_DIM (MAX_SCREEN_DIM)
	) u_project (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.xf        (xf),
		.dw        (dw),
		.dh        (dh),
		.out_valid (out_valid),
		.pix_x     (rsp.pixel_x),
		.pix_y     (rsp.pixel_y),
		.vis       (rsp.visible)
	);

	assign rsp.valid = out_valid;

endmodule
`default_nettype wire

// ===== dv/vertex_transform_project_unit_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// vertex_transform_project_unit_test
// Self-checking bench: matrix loads and vertices go in over req, projected
// pixels come back over rsp and are compared against an in-bench predictor.
// ---------------------------------------------------------------------------
`default_nettype none
module vertex_transform_project_unit_test;
	import vtp_pkg::*;

	localparam int LATENCY     = 17;
	localparam int WDOG_MAX    = 5000;
	localparam int FRAC        = 16;
	localparam int DIM_MAX     = 4096;
	localparam int HOLD_CYCLES = 200;

	typedef struct packed {
		logic [PIX_W-1:0] px;
		logic [PIX_W-1:0] py;
		logic             vis;
	} pix_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic wr_index;
	logic [DIM_CFG_W-1:0] wr_data;

	vtp_in_if  req ();
	vtp_out_if rsp ();

	vertex_transform_project_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req      (req.sink),
		.rsp      (rsp.source)
	);

	// predictor state: matrix copy and screen size
	logic signed [COORD_W-1:0] mat [N_ENTRIES];
	int unsigned scr_w, scr_h;

	item_t pending_items [$];
	pix_t  expected_pixels [$];
	int    n_mismatch;
	int    wdog;
	bit    timed_out;
	// receiver controls
	bit    hold_req;       // long hold-off requested by stimulus
	int    hold_cnt;       // hold-off cycles, counted by the receiver
	bit    hold_done;
	int    stall_mode;
	// sender controls
	int    burst_left, gap_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Q16.16 product shifted with floor (arithmetic shift does floor)
	function automatic longint fmul(longint a, longint b);
		return (a * b) >>> FRAC;
	endfunction

	function automatic longint sat(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint xform_col(longint x, longint y, longint z, int c);
		return sat(fmul(x, mat[c]) + fmul(y, mat[4 + c]) + fmul(z, mat[8 + c])
			+ longint'(mat[12 + c]));
	endfunction

	// one axis: num / (2w), in range when 0 <= value < dim
	function automatic bit axis_pos(longint num, longint w, longint dim,
			output longint pix);
		longint den;
		den = 2 * w;
		pix = 0;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (num < 0 || num >= dim * den)
			return 1'b0;
		pix = num / den;
		return 1'b1;
	endfunction

	function automatic pix_t project_vertex(item_t it);
		pix_t r;
		longint cx, cy, cw, dw, dh, px, py;
		bit okx, oky;
		cx = xform_col(it.vertex_x, it.vertex_y, it.vertex_z, 0);
		cy = xform_col(it.vertex_x, it.vertex_y, it.vertex_z, 1);
		cw = xform_col(it.vertex_x, it.vertex_y, it.vertex_z, 3);
		dw = (scr_w > DIM_MAX) ? DIM_MAX : scr_w;
		dh = (scr_h > DIM_MAX) ? DIM_MAX : scr_h;
		r = '0;
		if (cw != 0) begin
			okx = axis_pos(2 * dw * cx + dw * cw, cw, dw, px);
			oky = axis_pos(dh * cw - 2 * dh * cy, cw, dh, py);
			if (okx && oky) begin
				r.vis = 1'b1;
				r.px  = px[PIX_W-1:0];
				r.py  = py[PIX_W-1:0];
			end
		end
		return r;
	endfunction

	// ---------------- driver: bursts with random gaps ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			// transfer just completed: predict and retire the item
			if (req.valid && req.ready) begin
				if (req.cmd == CMD_LOAD)
					mat[req.entry_index] = req.entry_value;
				else
					expected_pixels.push_back(project_vertex(pending_items[0]));
				void'(pending_items.pop_front());
			end
			if (!req.valid || req.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					req.valid       <= 1'b1;
					req.cmd         <= pending_items[0].cmd;
					req.entry_index <= pending_items[0].entry_index;
					req.entry_value <= pending_items[0].entry_value;
					req.vertex_x    <= pending_items[0].vertex_x;
					req.vertex_y    <= pending_items[0].vertex_y;
					req.vertex_z    <= pending_items[0].vertex_z;
					if (burst_left > 0)
						burst_left <= burst_left - 1;
					else begin
						burst_left <= $urandom_range(30, 1);
						gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
					end
				end else
					req.valid <= 1'b0;
			end
		end
	end

	// ---------------- receiver stall pattern ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			rsp.ready <= 1'b0;
			if (hold_cnt < HOLD_CYCLES)
				hold_cnt <= hold_cnt + 1;
			else
				hold_done <= 1'b1;
		end else case (stall_mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= ($urandom_range(3, 0) != 0);
			default: rsp.ready <= ($urandom_range(2, 0) == 0);
		endcase
	end

	// ---------------- monitor and checker ----------------
	always @(posedge clk) begin
		pix_t exp_p;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_pixels.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected transfer: px=%0d py=%0d vis=%0d",
						rsp.pixel_x, rsp.pixel_y, rsp.visible);
			end else begin
				exp_p = expected_pixels.pop_front();
				if (rsp.pixel_x !== exp_p.px || rsp.pixel_y !== exp_p.py
						|| rsp.visible !== exp_p.vis) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: exp px=%0d py=%0d vis=%0d got px=%0d py=%0d vis=%0d",
							exp_p.px, exp_p.py, exp_p.vis,
							rsp.pixel_x, rsp.pixel_y, rsp.visible);
				end
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX && !timed_out) begin
			timed_out = 1'b1;
			$display("FAIL vertex_transform_project_unit");
			$finish;
		end
	end

	// ---------------- stimulus helpers ----------------
	task automatic add_load(input int idx, input logic [31:0] val);
		item_t it;
		it = '0;
		it.cmd = CMD_LOAD;
		it.entry_index = idx[IDX_W-1:0];
		it.entry_value = val;
		pending_items.push_back(it);
	endtask

	task automatic add_vertex(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		item_t it;
		it = '0;
		it.cmd = CMD_VERTEX;
		it.entry_index = IDX_W'($urandom());
		it.entry_value = $urandom();
		it.vertex_x = x;
		it.vertex_y = y;
		it.vertex_z = z;
		pending_items.push_back(it);
	endtask

	// wait until everything queued has gone through and the pipe is quiet
	task automatic drain();
		while (pending_items.size() > 0 || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_screen(input int unsigned w, input int unsigned h);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_WIDTH;
		wr_data <= w[DIM_CFG_W-1:0];
		@(posedge clk);
		wr_index <= REG_HEIGHT;
		wr_data <= h[DIM_CFG_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		scr_w = w & 13'h1fff;
		scr_h = h & 13'h1fff;
	endtask

	// random coordinate: mostly modest values, sometimes anything
	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(5, 0))
			0: return $urandom();
			1: return {$urandom_range(1, 0) ? 16'hffff : 16'h0000, 16'($urandom())};
			default: return 32'($signed($urandom_range(8 << 16, 0)) - (4 << 16));
		endcase
	endfunction

	function automatic logic [31:0] rnd_entry();
		case ($urandom_range(7, 0))
			0: return $urandom();
			1: return 32'h0;
			2: return 32'h0001_0000;
			default: return 32'($signed($urandom_range(3 << 16, 0)) - (3 << 15));
		endcase
	endfunction

	// load a perspective-like matrix with random content
	task automatic load_matrix();
		for (int i = 0; i < N_ENTRIES; i++)
			add_load(i, rnd_entry());
		// keep w mostly positive and sensible
		if ($urandom_range(3, 0) != 0) begin
			add_load(15, 32'h0001_0000 + $urandom_range(1 << 17, 0));
			add_load(11, $urandom_range(1 << 15, 0));
		end
	endtask

	// ---------------- main sequence ----------------
	initial begin
		int n_vtx;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_WIDTH;
		wr_data = '0;
		req.valid = 1'b0;
		req.cmd = CMD_LOAD;
		req.entry_index = '0;
		req.entry_value = '0;
		req.vertex_x = '0;
		req.vertex_y = '0;
		req.vertex_z = '0;
		rsp.ready = 1'b0;
		hold_req = 1'b0;
		stall_mode = 0;
		timed_out = 1'b0;
		n_mismatch = 0;
		wdog = 0;
		scr_w = RESET_WIDTH;
		scr_h = RESET_HEIGHT;
		for (int i = 0; i < N_ENTRIES; i++)
			mat[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero matrix gives w = 0, then identity-ish projections
		add_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		for (int i = 0; i < N_ENTRIES; i++)
			add_load(i, (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
		add_vertex(32'h0, 32'h0, 32'h0);                    // screen center
		add_vertex(32'hffff_8000, 32'h0000_8000, 32'h0);   // top-left corner
		add_vertex(32'h0000_8000, 32'hffff_8000, 32'h0);   // just off right and bottom edges
		add_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		add_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		add_load(15, 32'hffff_0000);                        // negative w
		add_vertex(32'h0000_4000, 32'h0000_4000, 32'h0);
		add_load(15, 32'h8000_0000);
		add_load(12, 32'h7fff_ffff);                        // extreme bias entries
		add_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		add_load(15, 32'h0);                                // w = 0 again
		add_vertex(32'h0, 32'h0, 32'h0);
		drain();

		// phases over screen sizes, extremes included
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_screen(1, 1);
				1: set_screen(4096, 4096);
				2: set_screen(8191, 5000);     // clamp above maximum
				3: set_screen(0, 480);         // nothing visible
				4: set_screen(640, 0);
				default: set_screen($urandom_range(4096, 1), $urandom_range(4096, 1));
			endcase
			stall_mode = ph % 3;
			load_matrix();
			n_vtx = 0;
			while (n_vtx < 80) begin
				if ($urandom_range(15, 0) == 0)
					add_load($urandom_range(15, 0), rnd_entry());
				add_vertex(rnd_coord(), rnd_coord(), rnd_coord());
				n_vtx++;
			end
			if (ph == 4) begin
				// long receiver hold-off while sender keeps offering
				hold_req = 1'b1;
			end
			drain();
		end
		set_screen(RESET_WIDTH, RESET_HEIGHT);

		drain();
		if (n_mismatch == 0 && expected_pixels.size() == 0)
			$display("PASS vertex_transform_project_unit");
		else
			$display("FAIL vertex_transform_project_unit");
		$finish;
	end

endmodule
`default_nettype wire
